// ----- design/vertex_dedup_indexer_top_assert.svh -----
// Assertion macros for the vertex indexer checker.
`ifndef VERTEX_DEDUP_INDEXER_TOP_ASSERT_SVH
`define VERTEX_DEDUP_INDEXER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define VDI_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vertex indexer check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define VDI_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vertex indexer check failed");

`endif

// ----- design/vdi_pkg.sv -----
// Shared types and constants for the vertex dedup indexer.
package vdi_pkg;

   // Default sizing
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int COORD_WIDTH_DEF = 32;

   // Fixed port widths
   localparam int FIELD_W = 32;
   localparam int IDX_W   = 10;
   localparam int THR_W   = 64;

   // Controller states
   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;       // capture vertex, clear scan pointer (and table on restart)
      logic issue;      // read the entry at the scan pointer and advance
      logic flush;      // drop everything in the compare pipeline
      logic append;     // write the captured vertex at the fill count
      logic rep_match;  // report index of the matching entry
      logic rep_new;    // report index of the appended entry
      logic rep_full;   // report a dropped vertex
   } ctl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic scan_done;  // every stored entry has been read
      logic pipe_busy;  // compare pipeline still holds entries
      logic hit;        // oldest entry in flight at the last stage matches
      logic full;       // no room left in the table
   } dp_status_type;

endpackage

// ----- design/vdi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module vdi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/vdi_datapath.sv -----
// Datapath: vertex table, distance pipeline, counters and result register.
module vdi_datapath #(
   parameter int TABLE_DEPTH = vdi_pkg::TABLE_DEPTH_DEF,
   parameter int COORD_WIDTH = vdi_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_restart,
   input  logic [vdi_pkg::FIELD_W-1:0]   req_vertex_x,
   input  logic [vdi_pkg::FIELD_W-1:0]   req_vertex_y,
   input  logic [vdi_pkg::FIELD_W-1:0]   req_vertex_z,
   input  logic                          csr_wr,
   input  logic [vdi_pkg::THR_W-1:0]     csr_data,
   input  vdi_pkg::ctl_cmd_type          cmd,
   output vdi_pkg::dp_status_type        status,
   output logic                          rsp_strobe,
   output logic [vdi_pkg::IDX_W-1:0]     rsp_vertex_index,
   output logic                          rsp_is_new,
   output logic                          rsp_table_full
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CW    = COORD_WIDTH;
   localparam int EW    = 3 * CW;
   localparam int SQ_W  = 2 * CW;
   localparam int TW    = vdi_pkg::THR_W;
   localparam int IW    = vdi_pkg::IDX_W;

   // |a - b| of two CW-bit two's complement values; fits in CW bits
   function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
      logic [CW:0] d;
      logic [CW:0] n;
      d = {a[CW-1], a} - {b[CW-1], b};
      n = (CW+1)'(0) - d;
      return d[CW] ? n[CW-1:0] : d[CW-1:0];
   endfunction

   // Threshold register
   logic [TW-1:0]    thr_ff, thr_in;
   // Captured vertex, lanes {z, y, x}
   logic [EW-1:0]    cur_ff, cur_in;
   // Fill count and scan pointer
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   // Pipeline valids and entry indexes
   logic             v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic [AW-1:0]    idx1_ff, idx1_in, idx2_ff, idx2_in;
   logic [AW-1:0]    idx3_ff, idx3_in, idx4_ff, idx4_in;
   // Pipeline payload
   logic [CW-1:0]    dabs_ff [3];
   logic [CW-1:0]    dabs_in [3];
   logic [SQ_W-1:0]  sq_ff [3];
   logic [SQ_W-1:0]  sq_in [3];
   logic [TW-1:0]    sxy_ff, sxy_in, sqz_ff, sqz_in;
   // Result beat
   logic             strobe_ff, strobe_in;
   logic [IW-1:0]    index_ff, index_in;
   logic             is_new_ff, is_new_in, full_ff, full_in;

   logic [EW-1:0]    ram_rd_data;
   logic [TW:0]      pair_sum;
   logic [TW:0]      total_sum;
   logic [TW-1:0]    dist_sq;
   logic             kill;

   // Vertex table
   vdi_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (cur_ff),
      .rd_en   (cmd.issue),
      .rd_addr (ptr_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Threshold, capture and counters
   always_comb begin
      thr_in   = csr_wr ? csr_data : thr_ff;
      cur_in   = cur_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (cmd.load) begin
         cur_in = {req_vertex_z[CW-1:0], req_vertex_y[CW-1:0], req_vertex_x[CW-1:0]};
         ptr_in = '0;
         if (req_restart) begin
            count_in = '0;
         end
      end
      if (cmd.issue) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
      if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // Pipeline valids and indexes; flush or a new load drops everything in flight
   assign kill = cmd.flush | cmd.load;

   always_comb begin
      v1_in   = cmd.issue & ~kill;
      v2_in   = v1_ff & ~kill;
      v3_in   = v2_ff & ~kill;
      v4_in   = v3_ff & ~kill;
      idx1_in = ptr_ff[AW-1:0];
      idx2_in = idx1_ff;
      idx3_in = idx2_ff;
      idx4_in = idx3_ff;
   end

   // Per-axis absolute difference and square
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dabs_in[k] = abs_diff(ram_rd_data[k*CW +: CW], cur_ff[k*CW +: CW]);
         sq_in[k]   = SQ_W'(dabs_ff[k]) * SQ_W'(dabs_ff[k]);
      end
   end

   // Saturating sum of x and y squares; z carried alongside
   always_comb begin
      pair_sum = (TW+1)'(sq_ff[0]) + (TW+1)'(sq_ff[1]);
      sxy_in   = pair_sum[TW] ? '1 : pair_sum[TW-1:0];
      sqz_in   = TW'(sq_ff[2]);
   end

   // Final saturating add and threshold compare
   always_comb begin
      total_sum = {1'b0, sxy_ff} + {1'b0, sqz_ff};
      dist_sq   = total_sum[TW] ? '1 : total_sum[TW-1:0];
   end

   assign status.hit       = v4_ff & (dist_sq <= thr_ff);
   assign status.pipe_busy = v1_ff | v2_ff | v3_ff | v4_ff;
   assign status.scan_done = (ptr_ff == count_ff);
   assign status.full      = (count_ff == CNT_W'(TABLE_DEPTH));

   // Result beat
   always_comb begin
      strobe_in = cmd.rep_match | cmd.rep_new | cmd.rep_full;
      is_new_in = cmd.rep_new;
      full_in   = cmd.rep_full;
      index_in  = '0;
      if (cmd.rep_match) begin
         index_in = IW'(idx4_ff);
      end else if (cmd.rep_new) begin
         index_in = IW'(count_ff[AW-1:0]);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= '0;
         count_ff  <= '0;
         ptr_ff    <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         thr_ff    <= thr_in;
         count_ff  <= count_in;
         ptr_ff    <= ptr_in;
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         v3_ff     <= v3_in;
         v4_ff     <= v4_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      idx1_ff   <= idx1_in;
      idx2_ff   <= idx2_in;
      idx3_ff   <= idx3_in;
      idx4_ff   <= idx4_in;
      dabs_ff   <= dabs_in;
      sq_ff     <= sq_in;
      sxy_ff    <= sxy_in;
      sqz_ff    <= sqz_in;
      index_ff  <= index_in;
      is_new_ff <= is_new_in;
      full_ff   <= full_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_vertex_index = index_ff;
   assign rsp_is_new       = is_new_ff;
   assign rsp_table_full   = full_ff;

endmodule

// ----- design/vdi_ctrl.sv -----
// Controller: sequences the table scan and picks the outcome of each vertex.
module vdi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  vdi_pkg::dp_status_type status,
   output vdi_pkg::ctl_cmd_type   cmd
);

   vdi_pkg::state_type state_ff, state_in;
   logic               scan_end;

   // No match anywhere once every entry is read and the pipeline is empty
   assign scan_end = status.scan_done & ~status.pipe_busy;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vdi_pkg::ST_IDLE: begin
            if (start) begin
               state_in = vdi_pkg::ST_SCAN;
            end
         end
         vdi_pkg::ST_SCAN: begin
            if (status.hit || scan_end) begin
               state_in = vdi_pkg::ST_IDLE;
            end
         end
         default: state_in = vdi_pkg::ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd  = '0;
      busy = 1'b0;
      unique case (state_ff)
         vdi_pkg::ST_IDLE: begin
            cmd.load = start;
         end
         vdi_pkg::ST_SCAN: begin
            busy = 1'b1;
            if (status.hit) begin
               cmd.rep_match = 1'b1;
               cmd.flush     = 1'b1;
            end else if (scan_end) begin
               if (status.full) begin
                  cmd.rep_full = 1'b1;
               end else begin
                  cmd.append  = 1'b1;
                  cmd.rep_new = 1'b1;
               end
            end else if (!status.scan_done) begin
               cmd.issue = 1'b1;
            end
         end
         default: begin
            cmd  = '0;
            busy = 1'b0;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vdi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/vertex_dedup_indexer_top.sv -----
// Vertex dedup indexer top level: welds near-equal vertices into an index table.
// A vertex is taken when start is high and busy is low. Busy then stays high
// while the table is read one stored entry per cycle, oldest first, through the
// single RAM read port into a four-stage distance pipeline (RAM read, axis
// difference, square, pair sum) that ends in the threshold compare. A vertex
// that matches entry i is reported with index i. A vertex that matches none
// of N stored entries is appended at index N (or dropped when the table holds
// TABLE_DEPTH entries) once every stored entry has been compared. The result
// is shown for exactly one cycle with rsp_strobe high and cannot be held off;
// a new vertex may be started in that same cycle. A restart vertex empties
// the table first.
// The threshold register is written through the csr_ port, which is always ready,
// and is only to be written while busy is low and no result is pending.
module vertex_dedup_indexer_top #(
   parameter int TABLE_DEPTH = vdi_pkg::TABLE_DEPTH_DEF,
   parameter int COORD_WIDTH = vdi_pkg::COORD_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // Vertex beat
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_restart,
   input  logic [vdi_pkg::FIELD_W-1:0] req_vertex_x,
   input  logic [vdi_pkg::FIELD_W-1:0] req_vertex_y,
   input  logic [vdi_pkg::FIELD_W-1:0] req_vertex_z,
   // Result beat
   output logic                        rsp_strobe,
   output logic [vdi_pkg::IDX_W-1:0]   rsp_vertex_index,
   output logic                        rsp_is_new,
   output logic                        rsp_table_full,
   // Threshold write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [vdi_pkg::THR_W-1:0]   csr_data
);

   vdi_pkg::ctl_cmd_type   cmd;
   vdi_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   // Sequencer
   vdi_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Table, distance pipeline and result register
   vdi_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_restart      (req_restart),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_vertex_z     (req_vertex_z),
      .csr_wr           (csr_valid & csr_ready),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_table_full   (rsp_table_full)
   );

endmodule

// ----- design/vdi_checker.sv -----
// Port-level checker for the vertex dedup indexer, bound to the top level.
`include "vertex_dedup_indexer_top_assert.svh"

module vdi_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_strobe,
   input logic [vdi_pkg::IDX_W-1:0] rsp_vertex_index,
   input logic                      rsp_is_new,
   input logic                      rsp_table_full
);

   // An accepted vertex keeps the block busy in the next cycle
   `VDI_ASSERT_NXT(a_accept_busy, start && !busy, busy)

   // A result beat closes the work on its vertex
   `VDI_ASSERT_IMP(a_rsp_frees, rsp_strobe, !busy && $past(busy))

   // One result beat per vertex
   `VDI_ASSERT_NXT(a_rsp_single, rsp_strobe, !rsp_strobe)

   // A dropped vertex reports index zero and is not new
   `VDI_ASSERT_IMP(a_full_beat, rsp_strobe && rsp_table_full, rsp_vertex_index == '0 && !rsp_is_new)

endmodule

bind vertex_dedup_indexer_top vdi_checker u_vdi_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_vertex_index (rsp_vertex_index),
   .rsp_is_new       (rsp_is_new),
   .rsp_table_full   (rsp_table_full)
);

// ----- verif/testbench.sv -----
// Self-checking testbench for vertex_dedup_indexer_top with a welding predictor.
`timescale 1ns / 100ps

module testbench;

   localparam int FIELD_W       = vdi_pkg::FIELD_W;
   localparam int IDX_W         = vdi_pkg::IDX_W;
   localparam int THR_W         = vdi_pkg::THR_W;
   localparam int DEPTH         = vdi_pkg::TABLE_DEPTH_DEF;
   localparam int COORD_W       = vdi_pkg::COORD_WIDTH_DEF;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_ITEMS  = 564;
   localparam int PHASES        = 6;
   localparam int MESH_LIMIT    = 40;

   localparam logic [FIELD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic [FIELD_W-1:0] COORD_MIN = 32'h8000_0000;
   localparam logic [THR_W-1:0]   THR_TOP   = {THR_W{1'b1}};

   typedef enum bit {OP_VERTEX, OP_THRESHOLD} op_kind_type;

   // One pending stimulus entry: a vertex or a threshold write
   typedef struct {
      op_kind_type        kind;
      logic [THR_W-1:0]   thr;
      logic               restart;
      logic [FIELD_W-1:0] x;
      logic [FIELD_W-1:0] y;
      logic [FIELD_W-1:0] z;
   } weld_op_type;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic             is_new;
      logic             full;
   } weld_result_type;

   // DUT ports
   logic               clock        = 1'b0;
   logic               reset        = 1'b1;
   logic               start        = 1'b0;
   logic               busy;
   logic               req_restart  = 1'b0;
   logic [FIELD_W-1:0] req_vertex_x = '0;
   logic [FIELD_W-1:0] req_vertex_y = '0;
   logic [FIELD_W-1:0] req_vertex_z = '0;
   logic               rsp_strobe;
   logic [IDX_W-1:0]   rsp_vertex_index;
   logic               rsp_is_new;
   logic               rsp_table_full;
   logic               csr_valid    = 1'b0;
   logic               csr_ready;
   logic [THR_W-1:0]   csr_data     = '0;

   // Stimulus and expected results
   weld_op_type        pending_ops[$];
   weld_result_type    weld_expect[$];
   weld_op_type        next_op;
   weld_result_type    exp_res;

   // Predictor copy of the vertex table and threshold
   logic [FIELD_W-1:0] weld_x [DEPTH];
   logic [FIELD_W-1:0] weld_y [DEPTH];
   logic [FIELD_W-1:0] weld_z [DEPTH];
   int                 weld_count     = 0;
   logic [THR_W-1:0]   weld_threshold = '0;

   // Generator view of the current mesh, for repeats and near-duplicates
   logic [FIELD_W-1:0] gen_x[$];
   logic [FIELD_W-1:0] gen_y[$];
   logic [FIELD_W-1:0] gen_z[$];

   int                 fail_cnt = 0;
   int                 burst_left;
   int                 hold_cnt;
   int                 settle_cnt;
   logic               nxt_start;
   logic               nxt_csr_valid;

   vertex_dedup_indexer_top #(
      .TABLE_DEPTH (DEPTH),
      .COORD_WIDTH (COORD_W)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_restart      (req_restart),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_vertex_z     (req_vertex_z),
      .rsp_strobe       (rsp_strobe),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_table_full   (rsp_table_full),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Squared distance along one axis, exact as an unsigned Q64.0 integer
   function automatic logic [THR_W-1:0] axis_dist_sq(input logic [FIELD_W-1:0] a,
                                                      input logic [FIELD_W-1:0] b);
      longint           sa;
      longint           sb;
      longint           diff;
      logic [THR_W-1:0] mag;
      sa   = $signed(a[COORD_W-1:0]);
      sb   = $signed(b[COORD_W-1:0]);
      diff = sa - sb;
      mag  = (diff < 0) ? -diff : diff;
      return mag * mag;
   endfunction

   function automatic logic [THR_W-1:0] sat_add(input logic [THR_W-1:0] a,
                                                 input logic [THR_W-1:0] b);
      logic [THR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[THR_W] ? THR_TOP : s[THR_W-1:0];
   endfunction

   // Weld one vertex into the predicted table and queue its expected result
   task automatic weld_vertex(input logic restart, input logic [FIELD_W-1:0] x,
                              input logic [FIELD_W-1:0] y, input logic [FIELD_W-1:0] z);
      weld_result_type  res;
      logic [THR_W-1:0] dist_acc;
      bit               found;
      found = 1'b0;
      res   = '0;
      if (restart) weld_count = 0;
      // first stored vertex within the threshold wins
      for (int i = 0; i < weld_count && !found; i++) begin
         dist_acc = axis_dist_sq(x, weld_x[i]);
         dist_acc = sat_add(dist_acc, axis_dist_sq(y, weld_y[i]));
         dist_acc = sat_add(dist_acc, axis_dist_sq(z, weld_z[i]));
         if (dist_acc <= weld_threshold) begin
            found     = 1'b1;
            res.index = i[IDX_W-1:0];
         end
      end
      if (!found) begin
         if (weld_count >= DEPTH) begin
            res.full = 1'b1;
         end else begin
            weld_x[weld_count] = x;
            weld_y[weld_count] = y;
            weld_z[weld_count] = z;
            res.index          = weld_count[IDX_W-1:0];
            res.is_new         = 1'b1;
            weld_count++;
         end
      end
      weld_expect.insert(weld_expect.size(), res);
   endtask

   task automatic push_vertex(input logic restart, input logic [FIELD_W-1:0] x,
                              input logic [FIELD_W-1:0] y, input logic [FIELD_W-1:0] z);
      weld_op_type op;
      op.kind    = OP_VERTEX;
      op.thr     = '0;
      op.restart = restart;
      op.x       = x;
      op.y       = y;
      op.z       = z;
      pending_ops.insert(pending_ops.size(), op);
   endtask

   task automatic push_threshold(input logic [THR_W-1:0] thr);
      weld_op_type op;
      op.kind    = OP_THRESHOLD;
      op.thr     = thr;
      op.restart = 1'b0;
      op.x       = '0;
      op.y       = '0;
      op.z       = '0;
      pending_ops.insert(pending_ops.size(), op);
   endtask

   function automatic logic [FIELD_W-1:0] jitter(input int unsigned spread);
      return $urandom_range(0, 2 * spread) - spread;
   endfunction

   function automatic logic [FIELD_W-1:0] pick_extreme();
      case ($urandom_range(0, 5))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return '0;
         3:       return '1;
         4:       return 32'd1;
         default: return $urandom;
      endcase
   endfunction

   // Random vertex: mostly repeats and near-duplicates of the current mesh
   task automatic gen_random_vertex(input int unsigned spread, input bit force_restart);
      logic [FIELD_W-1:0] vx;
      logic [FIELD_W-1:0] vy;
      logic [FIELD_W-1:0] vz;
      int unsigned        roll;
      int unsigned        pick;
      bit                 restart;
      roll    = $urandom_range(0, 99);
      restart = force_restart || gen_x.size() == 0 || gen_x.size() >= MESH_LIMIT || roll < 4;
      if (restart) begin
         gen_x.delete();
         gen_y.delete();
         gen_z.delete();
      end
      pick = (gen_x.size() != 0) ? $urandom_range(0, gen_x.size() - 1) : 0;
      if (gen_x.size() != 0 && roll < 40) begin
         vx = gen_x[pick];
         vy = gen_y[pick];
         vz = gen_z[pick];
      end else if (gen_x.size() != 0 && roll < 70) begin
         vx = gen_x[pick] + jitter(spread);
         vy = gen_y[pick] + jitter(spread);
         vz = gen_z[pick] + jitter(spread);
      end else if (roll < 85) begin
         vx = $urandom;
         vy = $urandom;
         vz = $urandom;
      end else begin
         vx = pick_extreme();
         vy = pick_extreme();
         vz = pick_extreme();
      end
      push_vertex(restart, vx, vy, vz);
      gen_x.insert(gen_x.size(), vx);
      gen_y.insert(gen_y.size(), vy);
      gen_z.insert(gen_z.size(), vz);
   endtask

   // Driver: vertex beats in bursts, threshold writes only once the block is quiet
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         csr_valid  <= 1'b0;
         burst_left  = $urandom_range(1, 12);
         hold_cnt    = 0;
         settle_cnt  = 0;
      end else begin
         nxt_start     = start;
         nxt_csr_valid = csr_valid;
         // threshold beat
         if (csr_valid && csr_ready) begin
            weld_threshold = csr_data;
            nxt_csr_valid  = 1'b0;
         end
         // vertex beat
         if (start && !busy) begin
            weld_vertex(req_restart, req_vertex_x, req_vertex_y, req_vertex_z);
            nxt_start = 1'b0;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               case ($urandom_range(0, 3))
                  0:       hold_cnt = 0;
                  1:       hold_cnt = $urandom_range(1, 40);
                  default: hold_cnt = $urandom_range(1, 5);
               endcase
            end
         end
         // quiet time before a threshold write
         if (!start && !busy && weld_expect.size() == 0) settle_cnt++;
         else settle_cnt = 0;
         if (hold_cnt != 0) begin
            hold_cnt--;
         end else if (!nxt_start && !nxt_csr_valid && pending_ops.size() != 0) begin
            if (pending_ops[0].kind == OP_VERTEX) begin
               next_op       = pending_ops.pop_front();
               req_restart  <= next_op.restart;
               req_vertex_x <= next_op.x;
               req_vertex_y <= next_op.y;
               req_vertex_z <= next_op.z;
               nxt_start     = 1'b1;
            end else if (settle_cnt >= SETTLE_CYCLES) begin
               next_op       = pending_ops.pop_front();
               csr_data     <= next_op.thr;
               nxt_csr_valid = 1'b1;
            end
         end
         start     <= nxt_start;
         csr_valid <= nxt_csr_valid;
      end
   end

   // Monitor: every result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (weld_expect.size() == 0) begin
            $display("%0t: expected no result, actual index %0d is_new %0b table_full %0b",
                     $time, rsp_vertex_index, rsp_is_new, rsp_table_full);
            fail_cnt++;
         end else begin
            exp_res = weld_expect.pop_front();
            if (rsp_vertex_index !== exp_res.index) begin
               $display("%0t: vertex_index expected %0d actual %0d",
                        $time, exp_res.index, rsp_vertex_index);
               fail_cnt++;
            end
            if (rsp_is_new !== exp_res.is_new) begin
               $display("%0t: is_new expected %0b actual %0b",
                        $time, exp_res.is_new, rsp_is_new);
               fail_cnt++;
            end
            if (rsp_table_full !== exp_res.full) begin
               $display("%0t: table_full expected %0b actual %0b",
                        $time, exp_res.full, rsp_table_full);
               fail_cnt++;
            end
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      logic [THR_W-1:0]   phase_thr;
      int unsigned        phase_spread;

      // exact welding at threshold zero, coordinate extremes
      push_threshold('0);
      push_vertex(1'b1, '0, '0, '0);
      push_vertex(1'b0, '0, '0, '0);
      push_vertex(1'b0, COORD_MAX, COORD_MAX, COORD_MAX);
      push_vertex(1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
      push_vertex(1'b0, COORD_MAX, COORD_MIN, '1);
      push_vertex(1'b0, '0, '0, 32'd1);
      push_vertex(1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
      // one LSB squared: a vertex one step from a stored entry welds to it
      push_threshold(64'd1);
      push_vertex(1'b0, '0, '0, 32'd2);
      push_vertex(1'b0, '0, '1, '0);
      // saturated distance welds only at the top threshold
      push_threshold(THR_TOP);
      push_vertex(1'b1, COORD_MAX, COORD_MAX, COORD_MAX);
      push_vertex(1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
      push_threshold(THR_TOP - 64'd1);
      push_vertex(1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
      push_vertex(1'b0, COORD_MIN, COORD_MIN, 32'h8000_0001);
      push_vertex(1'b0, 32'h7FFF_0000, COORD_MAX, COORD_MAX);
      push_vertex(1'b1, 32'h1234_5678, 32'h8765_4321, '0);

      // random phases over several thresholds
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               phase_thr    = '0;
               phase_spread = 3;
            end
            1: begin
               phase_thr    = 64'h0000_0001_0000_0000;
               phase_spread = 1 << 17;
            end
            2: begin
               phase_thr    = 64'h0000_0000_0010_0000;
               phase_spread = 1 << 11;
            end
            3: begin
               phase_thr    = {$urandom, $urandom} >> $urandom_range(0, 63);
               phase_spread = 1 << $urandom_range(0, 30);
            end
            4: begin
               phase_thr    = THR_TOP;
               phase_spread = 1 << 20;
            end
            default: begin
               phase_thr    = THR_TOP - 64'd1;
               phase_spread = 1 << 30;
            end
         endcase
         push_threshold(phase_thr);
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) gen_random_vertex(phase_spread, n == 0);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (pending_ops.size() != 0 || start || csr_valid || weld_expect.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_cnt == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // Watchdog, several times the slowest legal run
   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
